FILE: sv/hsfc_pkg.sv
// Package with constants and the conversion functions for the half/single converter.
package hsfc_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic {
    ACT_H2S = 1'b0,
    ACT_S2H = 1'b1
  } action_e;

  // Half to single, exact. Subnormals are normalized by a priority encoder.
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic       sgn;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] lz;
    logic [9:0] nm;
    logic [7:0] e;
    sgn = h[15];
    ex  = h[14:10];
    man = h[9:0];
    lz  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) lz = 4'(9 - i);
    end
    nm = 10'(man << (lz + 4'd1));
    e  = 8'(112) - 8'(lz);
    if (ex == 5'd0) begin
      if (man == 10'd0) widen_half = {sgn, 31'd0};
      else widen_half = {sgn, e, nm, 13'd0};
    end else if (ex == 5'h1F) begin
      widen_half = {sgn, 8'hFF, man, 13'd0};
    end else begin
      widen_half = {sgn, 8'(ex) + 8'd112, man, 13'd0};
    end
  endfunction

  // Single to half, round half away from zero.
  function automatic logic [15:0] narrow_single(input logic [31:0] f);
    logic [15:0] sgn;
    logic [7:0]  rex;
    logic [22:0] man;
    logic [23:0] fm;
    logic [4:0]  sh;
    logic [23:0] shd;
    logic [15:0] hm;
    sgn = {f[31], 15'd0};
    rex = f[30:23];
    man = f[22:0];
    fm  = {1'b1, man};
    // Subnormal range: raw exponent 102..112 gives shift 24..14. The shift is applied
    // one short so that the first dropped bit lands in bit 0.
    sh  = 5'(8'd125 - rex);
    shd = fm >> sh;
    hm  = 16'(shd[23:1]) + 16'(shd[0]);
    if (rex == 8'hFF) begin
      narrow_single = sgn | 16'h7C00 | (man != 23'd0 ? 16'h0200 : 16'h0000);
    end else if (rex >= 8'd143) begin
      narrow_single = sgn | 16'h7C00;
    end else if (rex <= 8'd112) begin
      if (rex < 8'd102) narrow_single = sgn;
      else narrow_single = sgn | hm;
    end else begin
      narrow_single = (sgn | {1'b0, 5'(rex - 8'd112), man[22:13]}) + 16'(man[12]);
    end
  endfunction

endpackage

FILE: sv/half_single_float_converter_top.sv
// Top level of the half/single precision converter.
// Usage: an item (action_i, operand_bits_i) is offered with in_valid_i and taken
// when in_ready_o is high. action_i low converts a half in the low 16 bits to a
// single; high converts a single to a half placed in the low 16 bits.
// The item is registered at the input, converted by combinational logic, and the
// result is captured in an output register shown with out_valid_o.
// out_valid_o rises once the item has passed through the input register and been
// captured in the output register; throughput is one item per cycle while the
// receiver keeps out_ready_i high, set by the two-stage register pipeline.
// When the receiver stalls the output register holds its item and the input
// register fills; in_ready_o drops only when both stages hold items and the
// receiver is not ready.
// Reset clears both valid flags; no item is in flight afterward.
module half_single_float_converter_top import hsfc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             action_i,
  input  logic [DataW-1:0] operand_bits_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] result_bits_o
);
  logic             s1_valid_q, s2_valid_q;
  logic             act_q;
  logic [DataW-1:0] op_q, res_d, res_q;
  logic             s2_load, s1_load;

  hsfc_core u_core (.action_i(act_q), .operand_bits_i(op_q), .result_bits_o(res_d));

  assign s2_load    = s1_valid_q && (!s2_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s2_load;
  assign s1_load    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (s2_load) s2_valid_q <= 1'b1;
      else if (out_ready_i) s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      act_q <= action_i;
      op_q  <= operand_bits_i;
    end
    if (s2_load) res_q <= res_d;
  end

  assign out_valid_o   = s2_valid_q;
  assign result_bits_o = res_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_bits_o))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s2_valid_q)
    else $error("input stalled without a full pipeline");
  a_half_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load && act_q |=> result_bits_o[31:16] == 16'd0)
    else $error("half result has upper bits set");
endmodule

FILE: sv/hsfc_core.sv
// Combinational conversion datapath for one item.
module hsfc_core import hsfc_pkg::*; (
  input  logic             action_i,
  input  logic [DataW-1:0] operand_bits_i,
  output logic [DataW-1:0] result_bits_o
);
  always_comb begin
    if (action_i == ACT_S2H) result_bits_o = {16'd0, narrow_single(operand_bits_i)};
    else result_bits_o = widen_half(operand_bits_i[15:0]);
  end
endmodule
